// ===== src/color_bar_pattern_generator_core_assert.svh =====
// assertion macros shared by the color bar pattern generator rtl
`ifndef COLOR_BAR_PATTERN_GENERATOR_CORE_ASSERT_SVH
`define COLOR_BAR_PATTERN_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbp assertion failed");

// next-cycle implication, checked outside reset
`define CBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbp assertion failed");

`endif

// ===== src/cbp_pkg.sv =====
// types, constants and the bar color table of the color bar pattern generator
`timescale 1ns / 1ps
`default_nettype none

package cbp_pkg;

    // sizes
    localparam int CBP_MAX_DIM   = 4096;
    localparam int CBP_COORD_W   = $clog2(CBP_MAX_DIM);
    localparam int CBP_DIM_W     = CBP_COORD_W + 1;
    localparam int CBP_THR_W     = CBP_DIM_W + 3;
    localparam int CBP_FRAME_W   = 24;
    localparam int CBP_DIVD_W    = CBP_FRAME_W + 2;
    localparam int CBP_BAND_H_W  = CBP_DIM_W - 4;
    localparam int CBP_CFG_IDX_W = 2;
    localparam int CBP_CFG_DAT_W = CBP_FRAME_W;

    // register indexes
    localparam logic [CBP_CFG_IDX_W-1:0] CBP_REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CBP_CFG_IDX_W-1:0] CBP_REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CBP_CFG_IDX_W-1:0] CBP_REG_TOTAL_FRAMES = 2'd2;

    // register reset values
    localparam logic [CBP_DIM_W-1:0]   CBP_WIDTH_RST  = 13'd640;
    localparam logic [CBP_DIM_W-1:0]   CBP_HEIGHT_RST = 13'd480;
    localparam logic [CBP_FRAME_W-1:0] CBP_TOTAL_RST  = 24'd300;

    localparam logic [7:0] CBP_ALPHA_ON = 8'd255;

    // input word
    typedef struct packed {
        logic [CBP_COORD_W-1:0] pixel_x;
        logic [CBP_COORD_W-1:0] pixel_y;
        logic [CBP_FRAME_W-1:0] frame_number;
    } cbp_in_t;

    // result word
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       in_band;
        logic       end_of_stream;
    } cbp_out_t;

    // per-pixel data that rides along the remainder pipe
    typedef struct packed {
        logic [2:0]             bar;
        logic [CBP_COORD_W-1:0] pixel_y;
        logic                   eos;
    } cbp_side_t;

    // one remainder pipe stage
    typedef struct packed {
        logic [CBP_DIM_W-1:0]  rem;
        logic [CBP_DIVD_W-1:0] divd;
        cbp_side_t             side;
    } cbp_div_t;

    // eight-bar color table, {red, green, blue}
    function automatic logic [23:0] cbp_bar_color(input logic [2:0] bar);
        logic [23:0] rgb;
        case (bar)
            3'd0:    rgb = {8'd192, 8'd192, 8'd192};
            3'd1:    rgb = {8'd192, 8'd192, 8'd0};
            3'd2:    rgb = {8'd0,   8'd192, 8'd192};
            3'd3:    rgb = {8'd0,   8'd192, 8'd0};
            3'd4:    rgb = {8'd192, 8'd0,   8'd192};
            3'd5:    rgb = {8'd192, 8'd0,   8'd0};
            3'd6:    rgb = {8'd0,   8'd0,   8'd192};
            default: rgb = {8'd16,  8'd16,  8'd16};
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

// ===== src/cbp_rem_step.sv =====
// one restoring step of the band start remainder, one dividend bit per stage
`timescale 1ns / 1ps
`default_nettype none

module cbp_rem_step (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire cbp_pkg::cbp_div_t            in_word,
    input  wire logic [cbp_pkg::CBP_DIM_W-1:0] divisor,
    output logic                              out_valid,
    output cbp_pkg::cbp_div_t                 out_word
);
    import cbp_pkg::*;

    logic              valid_reg;
    cbp_div_t          word_reg;
    cbp_div_t          word_next;
    logic [CBP_DIM_W:0] trial;
    logic [CBP_DIM_W:0] dvs;

    // shift in the next dividend bit and subtract when it fits
    always_comb
    begin
        trial = {in_word.rem, in_word.divd[CBP_DIVD_W-1]};
        dvs   = {1'b0, divisor};
        word_next      = in_word;
        word_next.divd = {in_word.divd[CBP_DIVD_W-2:0], 1'b0};
        if (trial >= dvs)
        begin
            word_next.rem = CBP_DIM_W'(trial - dvs);
        end
        else
        begin
            word_next.rem = CBP_DIM_W'(trial);
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ===== src/cbp_out_buf.sv =====
// two-word output buffer that decouples the pipe from the result consumer
`timescale 1ns / 1ps
`default_nettype none

module cbp_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire cbp_pkg::cbp_out_t in_word,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cbp_pkg::cbp_out_t      out_word
);
    import cbp_pkg::*;

    logic     out_valid_reg;
    logic     out_valid_next;
    cbp_out_t out_word_reg;
    cbp_out_t out_word_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    cbp_out_t skid_word_reg;
    cbp_out_t skid_word_next;
    logic     push;
    logic     take;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && !skid_valid_reg;
    assign take     = out_valid_reg && out_ready;

    // refill the output word from the skid word first, then from the pipe
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_next = 1'b1;
                out_word_next  = in_word;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_word_next  = in_word;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

// ===== src/color_bar_pattern_generator_core.sv =====
// top level of the color bar pattern generator
`timescale 1ns / 1ps
`default_nettype none

// Color bar pattern generator: takes one pixel word (column, row, frame) per clock and
// returns its RGBA color, one result word per input word, in order. Throughput is one
// word per clock while in_ready is high; the output buffer stalls the pipe when full.
// A word passes through one input register, one stage per bit of frame_number*4 (26
// stages) in the pipelined remainder unit that finds the band start row, and the
// output register. The output buffer holds two words, so the pipe keeps accepting
// while one finished word waits. Configuration registers are read directly by every
// stage and must be written only while no word is in flight.
module color_bar_pattern_generator_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [cbp_pkg::CBP_CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cbp_pkg::CBP_CFG_DAT_W-1:0] cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire cbp_pkg::cbp_in_t                  in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output cbp_pkg::cbp_out_t                      out_data
);
    import cbp_pkg::*;

    logic [CBP_DIM_W-1:0]   frame_width_reg;
    logic [CBP_DIM_W-1:0]   frame_height_reg;
    logic [CBP_FRAME_W-1:0] total_frames_reg;
    logic [CBP_DIM_W-1:0]   w_eff;
    logic [CBP_DIM_W-1:0]   h_eff;

    logic                   pipe_en;
    logic                   s0_valid_reg;
    cbp_in_t                s0_data_reg;

    logic                   stage_valid [0:CBP_DIVD_W];
    cbp_div_t               stage_word  [0:CBP_DIVD_W];

    logic [2:0]             bar_cnt;
    logic [CBP_THR_W-1:0]   thr;
    logic [CBP_THR_W-1:0]   x_scaled;

    logic [CBP_BAND_H_W-1:0] band_h;
    logic [CBP_DIM_W:0]      band_end;
    logic                    band;
    logic [23:0]             rgb;
    cbp_div_t                last_word;
    cbp_out_t                result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CBP_WIDTH_RST;
            frame_height_reg <= CBP_HEIGHT_RST;
            total_frames_reg <= CBP_TOTAL_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CBP_REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[CBP_DIM_W-1:0];
                CBP_REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[CBP_DIM_W-1:0];
                CBP_REG_TOTAL_FRAMES: total_frames_reg <= cfg_data[CBP_FRAME_W-1:0];
                default:              ;
            endcase
        end
    end

    // zero dimensions count as one
    assign w_eff = (frame_width_reg == '0) ? CBP_DIM_W'(1) : frame_width_reg;
    assign h_eff = (frame_height_reg == '0) ? CBP_DIM_W'(1) : frame_height_reg;

    assign in_ready = pipe_en;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s0_data_reg <= in_data;
        end
    end

    // bar index: count the multiples k*width, k = 1..7, at or below 8*x
    always_comb
    begin
        thr      = '0;
        bar_cnt  = 3'd0;
        x_scaled = CBP_THR_W'({s0_data_reg.pixel_x, 3'b000});
        for (int k = 1; k < 8; k++)
        begin
            thr = CBP_THR_W'(w_eff) * CBP_THR_W'(k);
            if (x_scaled >= thr)
            begin
                bar_cnt = bar_cnt + 3'd1;
            end
        end
    end

    // seed the remainder pipe with frame*4 and the per-pixel side data
    always_comb
    begin
        stage_word[0].rem          = '0;
        stage_word[0].divd         = {s0_data_reg.frame_number, 2'b00};
        stage_word[0].side.bar     = bar_cnt;
        stage_word[0].side.pixel_y = s0_data_reg.pixel_y;
        stage_word[0].side.eos     = (s0_data_reg.frame_number >= total_frames_reg);
    end

    assign stage_valid[0] = s0_valid_reg;

    // band start = (frame*4) mod height, one dividend bit per stage
    for (genvar i = 0; i < CBP_DIVD_W; i++)
    begin : g_rem
        cbp_rem_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (stage_valid[i]),
            .in_word   (stage_word[i]),
            .divisor   (h_eff),
            .out_valid (stage_valid[i+1]),
            .out_word  (stage_word[i+1])
        );
    end

    assign last_word = stage_word[CBP_DIVD_W];

    // band test and color selection
    always_comb
    begin
        band_h = h_eff[CBP_DIM_W-1:4];
        if (band_h == '0)
        begin
            band_h = CBP_BAND_H_W'(1);
        end
        band_end = {1'b0, last_word.rem} + (CBP_DIM_W+1)'(band_h);
        band     = (CBP_DIM_W'(last_word.side.pixel_y) >= last_word.rem)
                && ((CBP_DIM_W+1)'(last_word.side.pixel_y) < band_end);
        rgb      = cbp_bar_color(last_word.side.bar);
        if (band)
        begin
            rgb = ~rgb;
        end
        if (last_word.side.eos)
        begin
            result.red           = 8'd0;
            result.green         = 8'd0;
            result.blue          = 8'd0;
            result.alpha         = 8'd0;
            result.in_band       = 1'b0;
            result.end_of_stream = 1'b1;
        end
        else
        begin
            result.red           = rgb[23:16];
            result.green         = rgb[15:8];
            result.blue          = rgb[7:0];
            result.alpha         = CBP_ALPHA_ON;
            result.in_band       = band;
            result.end_of_stream = 1'b0;
        end
    end

    // output buffer
    cbp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[CBP_DIVD_W]),
        .in_word   (result),
        .in_ready  (pipe_en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_data)
    );

    // checks
`include "color_bar_pattern_generator_core_assert.svh"

    `CBP_ASSERT_IMP(a_rem_below_height, clk, rst_n, stage_valid[CBP_DIVD_W], last_word.rem < h_eff)
    `CBP_ASSERT_IMP(a_eos_black, clk, rst_n, out_valid && out_data.end_of_stream, out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0 && out_data.alpha == 8'd0 && !out_data.in_band)
    `CBP_ASSERT_IMP(a_band_inverted, clk, rst_n, out_valid && out_data.in_band, out_data.red == 8'd255 || out_data.red == 8'd63 || out_data.red == 8'd239)
    `CBP_ASSERT_NXT(a_stall_holds_pipe, clk, rst_n, !pipe_en && stage_valid[CBP_DIVD_W], stage_valid[CBP_DIVD_W])

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the color bar pattern generator core
`timescale 1ns / 1ps

module testbench;

    import cbp_pkg::*;

    // pipeline depth from input accept to result valid
    localparam int PIPE_LATENCY = 28;
    // cycles with no word moving on either side before the run is declared hung
    localparam int HANG_LIMIT   = 4000;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     cfg_wr_en  = 1'b0;
    logic [CBP_CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CBP_CFG_DAT_W-1:0] cfg_data   = '0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    cbp_in_t                  in_data    = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    cbp_out_t                 out_data;

    // shadow copy of the frame registers
    logic [CBP_DIM_W-1:0]   frame_width_reg  = 13'd640;
    logic [CBP_DIM_W-1:0]   frame_height_reg = 13'd480;
    logic [CBP_FRAME_W-1:0] total_frames_reg = 24'd300;

    // bar colors as {red, green, blue}
    logic [23:0] bar_palette [0:7] = '{
        24'hC0C0C0, 24'hC0C000, 24'h00C0C0, 24'h00C000,
        24'hC000C0, 24'hC00000, 24'h0000C0, 24'h101010
    };

    cbp_out_t pixel_color_pending [$];
    cbp_out_t oldest_color;
    int       mismatch_count = 0;
    int       quiet_cycles   = 0;
    int       ready_left     = 0;
    bit       tx_idle_en     = 1'b1;
    bit       rx_stall_en    = 1'b1;

    color_bar_pattern_generator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // color of one pixel under the current register settings
    function automatic cbp_out_t predict_pixel_color(input cbp_in_t px);
        cbp_out_t        res;
        longint unsigned w, h, x, y, frame, bar, band_h, band_y;
        logic [23:0]     rgb;
        logic            hit;
        res = '0;
        if (px.frame_number >= total_frames_reg)
        begin
            res.end_of_stream = 1'b1;
            return res;
        end
        w      = (frame_width_reg == 0) ? 1 : frame_width_reg;
        h      = (frame_height_reg == 0) ? 1 : frame_height_reg;
        x      = px.pixel_x;
        y      = px.pixel_y;
        frame  = px.frame_number;
        bar    = (x * 8) / w;
        if (bar > 7)
            bar = 7;
        band_h = h / 16;
        if (band_h < 1)
            band_h = 1;
        band_y = (frame * 4) % h;
        hit    = (y >= band_y) && (y < band_y + band_h);
        rgb    = bar_palette[bar];
        res.red     = hit ? 8'd255 - rgb[23:16] : rgb[23:16];
        res.green   = hit ? 8'd255 - rgb[15:8]  : rgb[15:8];
        res.blue    = hit ? 8'd255 - rgb[7:0]   : rgb[7:0];
        res.alpha   = CBP_ALPHA_ON;
        res.in_band = hit;
        return res;
    endfunction

    function automatic cbp_in_t make_pixel(input int unsigned x, y, f);
        cbp_in_t px;
        px.pixel_x      = CBP_COORD_W'(x);
        px.pixel_y      = CBP_COORD_W'(y);
        px.frame_number = CBP_FRAME_W'(f);
        return px;
    endfunction

    // mostly short idle gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_dimension();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        else if (r < 20)
            return $urandom_range(1, 20);
        else if (r < 28)
            return 4096;
        else if (r < 33)
            return 8191;
        else
            return $urandom_range(1, 4096);
    endfunction

    function automatic int unsigned pick_total();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom_range(0, 8);
        else if (r < 45)
            return 24'hFFFFFF;
        else
            return $urandom_range(1, 24'hFFFFFF);
    endfunction

    // random pixel, weighted toward the visible frame and the band rows
    function automatic cbp_in_t random_pixel();
        int unsigned     w, h, band_h, r;
        longint unsigned frame, band_y;
        int              yv;
        cbp_in_t         px;
        w = (frame_width_reg == 0) ? 1 : frame_width_reg;
        h = (frame_height_reg == 0) ? 1 : frame_height_reg;
        px.pixel_x = ($urandom_range(0, 9) < 8) ?
                     CBP_COORD_W'($urandom_range(0, ((w > 4096) ? 4096 : w) - 1)) :
                     CBP_COORD_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 75)
            frame = (total_frames_reg == 0) ? $urandom :
                    $urandom_range(0, total_frames_reg - 1);
        else if (r < 85)
            frame = longint'(total_frames_reg) + $urandom_range(0, 4) - 2;
        else
            frame = $urandom;
        px.frame_number = CBP_FRAME_W'(frame);
        band_h = (h / 16 < 1) ? 1 : h / 16;
        band_y = (longint'(px.frame_number) * 4) % h;
        r = $urandom_range(0, 99);
        if (r < 55)
            yv = int'(band_y) + $urandom_range(0, band_h + 1) - 1;
        else if (r < 85)
            yv = $urandom_range(0, ((h > 4096) ? 4096 : h) - 1);
        else
            yv = $urandom;
        px.pixel_y = CBP_COORD_W'(yv);
        return px;
    endfunction

    // present one pixel word and hold it until the core takes it
    task automatic send_pixel(input cbp_in_t px);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        pixel_color_pending.push_back(predict_pixel_color(px));
    endtask

    // stop sending and wait for every pending color to come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pixel_color_pending.size() != 0);
    endtask

    task automatic settle_pipeline();
        wait_for_results();
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    // write all three frame registers on an idle core
    task automatic apply_frame_config(input int unsigned w, h, t);
        settle_pipeline();
        cfg_wr_en <= 1'b1;
        cfg_index <= CBP_REG_FRAME_WIDTH;
        cfg_data  <= CBP_CFG_DAT_W'(w);
        @(posedge clk);
        cfg_index <= CBP_REG_FRAME_HEIGHT;
        cfg_data  <= CBP_CFG_DAT_W'(h);
        @(posedge clk);
        cfg_index <= CBP_REG_TOTAL_FRAMES;
        cfg_data  <= CBP_CFG_DAT_W'(t);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        frame_width_reg  = CBP_DIM_W'(w);
        frame_height_reg = CBP_DIM_W'(h);
        total_frames_reg = CBP_FRAME_W'(t);
    endtask

    // reset settings 640x480, 300 frames: bar edges, band edges, end of stream
    task automatic test_reset_values();
        send_pixel(make_pixel(0, 0, 0));
        send_pixel(make_pixel(79, 29, 0));
        send_pixel(make_pixel(80, 30, 0));
        send_pixel(make_pixel(639, 100, 1));
        send_pixel(make_pixel(640, 0, 299));
        send_pixel(make_pixel(4095, 236, 299));
        send_pixel(make_pixel(100, 265, 299));
        send_pixel(make_pixel(100, 266, 299));
        send_pixel(make_pixel(0, 0, 300));
        send_pixel(make_pixel(4095, 4095, 24'hFFFFFF));
    endtask

    // zero width and height act as one
    task automatic test_zero_dimensions();
        apply_frame_config(0, 0, 1);
        send_pixel(make_pixel(0, 0, 0));
        send_pixel(make_pixel(1, 1, 0));
        send_pixel(make_pixel(0, 0, 1));
    endtask

    // band at the bottom reaches past the last row without wrapping
    task automatic test_band_edges();
        apply_frame_config(4096, 100, 24'hFFFFFF);
        send_pixel(make_pixel(4095, 99, 24));
        send_pixel(make_pixel(2048, 101, 24));
        send_pixel(make_pixel(512, 102, 24));
        send_pixel(make_pixel(0, 0, 24'hFFFFFE));
        send_pixel(make_pixel(0, 4095, 24'hFFFFFF));
        apply_frame_config(1, 16, 2);
        send_pixel(make_pixel(0, 4, 1));
        send_pixel(make_pixel(1, 5, 1));
    endtask

    // widest frame width and an empty stream
    task automatic test_wide_frame();
        apply_frame_config(8191, 4096, 0);
        send_pixel(make_pixel(0, 0, 0));
        apply_frame_config(8191, 4096, 16);
        send_pixel(make_pixel(4095, 0, 0));
        send_pixel(make_pixel(4095, 4095, 15));
        send_pixel(make_pixel(1023, 255, 0));
    endtask

    // bursts separated by a full drain of the pipe
    task automatic test_burst_drain();
        apply_frame_config(640, 480, 300);
        for (int b = 0; b < 4; b++)
        begin
            for (int n = 0; n < 15; n++)
                send_pixel(random_pixel());
            wait_for_results();
        end
    endtask

    // random pixels over a series of random frame settings
    task automatic test_random_frames();
        for (int phase = 0; phase < 10; phase++)
        begin
            apply_frame_config(pick_dimension(), pick_dimension(), pick_total());
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 170; n++)
            begin
                if ($urandom_range(0, 199) == 0)
                    wait_for_results();
                send_pixel(random_pixel());
            end
        end
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // result side back-pressure: runs of ready, then stalls of random length
    always @(posedge clk)
    begin
        if (ready_left != 0)
            ready_left--;
        else if (!rx_stall_en)
            out_ready <= 1'b1;
        else if (out_ready)
        begin
            out_ready  <= 1'b0;
            ready_left = pick_gap();
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_left = ($urandom_range(0, 99) < 15) ? $urandom_range(50, 200) :
                                                        $urandom_range(0, 12);
        end
    end

    // compare each result word with the oldest pending color
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pixel_color_pending.size() == 0)
            begin
                $error("result word with no pixel pending: %p", out_data);
                mismatch_count++;
            end
            else
            begin
                oldest_color = pixel_color_pending.pop_front();
                if (out_data.red !== oldest_color.red)
                begin
                    $error("red: expected %0d, got %0d", oldest_color.red, out_data.red);
                    mismatch_count++;
                end
                if (out_data.green !== oldest_color.green)
                begin
                    $error("green: expected %0d, got %0d",
                           oldest_color.green, out_data.green);
                    mismatch_count++;
                end
                if (out_data.blue !== oldest_color.blue)
                begin
                    $error("blue: expected %0d, got %0d", oldest_color.blue, out_data.blue);
                    mismatch_count++;
                end
                if (out_data.alpha !== oldest_color.alpha)
                begin
                    $error("alpha: expected %0d, got %0d",
                           oldest_color.alpha, out_data.alpha);
                    mismatch_count++;
                end
                if (out_data.in_band !== oldest_color.in_band)
                begin
                    $error("in_band: expected %0d, got %0d",
                           oldest_color.in_band, out_data.in_band);
                    mismatch_count++;
                end
                if (out_data.end_of_stream !== oldest_color.end_of_stream)
                begin
                    $error("end_of_stream: expected %0d, got %0d",
                           oldest_color.end_of_stream, out_data.end_of_stream);
                    mismatch_count++;
                end
            end
        end
    end

    // hang detection: too long with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_zero_dimensions();
        test_band_edges();
        test_wide_frame();
        test_burst_drain();
        test_random_frames();
        settle_pipeline();
        if (mismatch_count == 0 && pixel_color_pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
